// ----- rtl/c3nc_pkg.sv -----
// ----------------------------------------------------------------------------
// c3nc_pkg: shared types and constants for the 3x3 normalized convolution
// Holds field widths, register indexes, reset values and the front-to-back
// job record.
// ----------------------------------------------------------------------------
package c3nc_pkg;

  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int TAP_BITS_DEF   = 5;

  localparam int PIX_W   = 8;
  localparam int ROW_W   = 12;
  localparam int COL_W   = 9;
  localparam int TAPS_W  = 45;
  localparam int IW_W    = 10;
  localparam int IH_W    = 13;
  localparam int CFG_W   = 45;
  localparam int IDX_W   = 2;

  localparam logic [IDX_W-1:0] REG_TAPS   = 2'd0;
  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic [TAPS_W-1:0] TAPS_RESET = 45'd1132865717279;
  localparam logic [IW_W-1:0]   WIDTH_RESET  = 10'd512;
  localparam logic [IH_W-1:0]   HEIGHT_RESET = 13'd512;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam int PIX_MAX = 255;

  // Job handed from the front part to the arithmetic back part.
  typedef struct packed {
    logic [8:0][PIX_W-1:0] win;
    logic                  interior;
    logic [ROW_W-1:0]      row;
    logic [COL_W-1:0]      col;
    logic                  last;
  } job_t;

endpackage

// ----- rtl/c3nc_if.sv -----
// ----------------------------------------------------------------------------
// c3nc_stream_if: valid/ready channel carrying one payload
// Generic stream interface with source and sink views.
// ----------------------------------------------------------------------------
interface c3nc_stream_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/conv3x3_normalized_clamp.sv -----
// ----------------------------------------------------------------------------
// conv3x3_normalized_clamp: streaming 3x3 normalized convolution with clamp
// Front part keeps line stores and window; back part divides and clamps.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  in_ch    | in  | operation, pixel
//  out_ch   | out | result_pixel, out_row, out_col, frame_end
//  cfg      | in  | cfg_we, cfg_index, cfg_data
// A pixel transaction in the front part waits for its line store read before it
// can issue a job. Each output goes through the back part's sum, divide and done
// states and then back to idle; the back part takes no new job until its result
// has been taken.
// After reset a clearing sweep over all MAX_WIDTH line store entries holds input ready low.
// A two-entry queue lets the front keep going while the back is stalled.
module conv3x3_normalized_clamp #(
  parameter int MAX_WIDTH  = c3nc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = c3nc_pkg::MAX_HEIGHT_DEF,
  parameter int TAP_BITS   = c3nc_pkg::TAP_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  c3nc_stream_if.sink                  in_ch,
  c3nc_stream_if.source                out_ch,
  input  logic                         cfg_we,
  input  logic [c3nc_pkg::IDX_W-1:0]   cfg_index,
  input  logic [c3nc_pkg::CFG_W-1:0]   cfg_data
);
  import c3nc_pkg::*;

  logic [TAPS_W-1:0] taps;
  logic [IW_W-1:0]   width;
  logic [IH_W-1:0]   height;
  logic              restart;
  logic              fj_valid, fj_ready, bj_valid, bj_ready;
  job_t              fj, bj;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      taps <= TAPS_RESET; width <= WIDTH_RESET; height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TAPS:   taps   <= cfg_data[TAPS_W-1:0];
        REG_WIDTH:  width  <= cfg_data[IW_W-1:0];
        REG_HEIGHT: height <= cfg_data[IH_W-1:0];
        default: ;
      endcase
    end
  end
  assign restart = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

  c3nc_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_op(in_ch.data.operation), .in_pix(in_ch.data.pixel),
    .geo_restart(restart), .cfg_width(width), .cfg_height(height),
    .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
  );

  c3nc_queue u_queue (
    .clk, .rst, .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
    .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
  );

  c3nc_back #(.TAP_BITS(TAP_BITS)) u_back (
    .clk, .rst, .taps, .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
    .res_valid(out_ch.valid), .res_ready(out_ch.ready),
    .res_pix(out_ch.data.result_pixel), .res_row(out_ch.data.out_row),
    .res_col(out_ch.data.out_col), .res_last(out_ch.data.frame_end)
  );
endmodule

// ----- rtl/c3nc_front.sv -----
// ----------------------------------------------------------------------------
// c3nc_front: line stores, window and position tracking
// Accepts pixel and drain transactions, updates the window and issues one
// job for each transaction that yields an output pixel.
// ----------------------------------------------------------------------------
module c3nc_front #(
  parameter int MAX_WIDTH  = c3nc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = c3nc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [c3nc_pkg::PIX_W-1:0]    in_pix,
  input  logic                          geo_restart,
  input  logic [c3nc_pkg::IW_W-1:0]     cfg_width,
  input  logic [c3nc_pkg::IH_W-1:0]     cfg_height,
  output logic                          job_valid,
  input  logic                          job_ready,
  output c3nc_pkg::job_t                job
);
  import c3nc_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int PW = $clog2(MAX_WIDTH + 2);

  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
  logic [AW:0]      clr_idx;
  logic             clearing;

  // Stage one: accepted pixel waiting for line store read data.
  logic             s1_valid;
  logic [PIX_W-1:0] s1_pix;
  logic [AW-1:0]    s1_addr;
  logic [PIX_W-1:0] rd_top, rd_mid;
  logic             s1_emit;

  logic [8:0][PIX_W-1:0] win;
  logic [ROW_W-1:0] in_row, out_row;
  logic [COL_W-1:0] in_col, out_col;
  logic [PW-1:0]    pending;

  logic [IW_W-1:0] w_eff;
  logic [IH_W-1:0] h_eff;
  logic            acc, is_pix, do_emit_pix, do_drain, issue;
  logic [AW-1:0]   rd_addr;

  always_comb begin
    if (cfg_width == '0) w_eff = IW_W'(1);
    else if (32'(cfg_width) > MAX_WIDTH) w_eff = IW_W'(MAX_WIDTH);
    else w_eff = cfg_width;
    if (cfg_height == '0) h_eff = IH_W'(1);
    else if (32'(cfg_height) > MAX_HEIGHT) h_eff = IH_W'(MAX_HEIGHT);
    else h_eff = cfg_height;
  end

  // One transaction at a time through the two stages; stall on job output.
  assign in_ready    = !clearing && !s1_valid && !(job_valid && !job_ready);
  assign acc         = in_valid && in_ready;
  assign is_pix      = (in_op == OP_PIXEL);
  assign do_emit_pix = 32'(pending) >= 32'(w_eff) + 1;
  assign do_drain    = (pending != '0) && (in_row == '0) && (in_col == '0);
  assign rd_addr     = AW'(in_col);
  assign issue       = (s1_valid && s1_emit) || (acc && !is_pix && do_drain);

  // Line store memories: cleared by a sweep after reset, then read and written.
  // The write in stage one goes to the column captured when the pixel was taken.
  always_ff @(posedge clk) begin
    if (clearing) begin
      upper_mem[clr_idx[AW-1:0]]  <= '0;
      middle_mem[clr_idx[AW-1:0]] <= '0;
    end else if (s1_valid) begin
      upper_mem[s1_addr]  <= rd_mid;
      middle_mem[s1_addr] <= s1_pix;
    end
    if (acc) begin
      rd_top <= upper_mem[rd_addr];
      rd_mid <= middle_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      clearing <= 1'b1;
    end else if (clearing) begin
      clr_idx  <= clr_idx + 1'b1;
      clearing <= (32'(clr_idx) != MAX_WIDTH - 1);
    end
  end

  // Position, pending count, window and job issue.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      job_valid <= 1'b0;
      in_row <= '0; in_col <= '0; out_row <= '0; out_col <= '0;
      pending <= '0;
      win <= '0;
    end else begin
      if (job_valid && job_ready && !issue) job_valid <= 1'b0;
      if (geo_restart) begin
        in_row <= '0; in_col <= '0; out_row <= '0; out_col <= '0;
        pending <= '0;
      end
      if (acc) begin
        s1_pix <= in_pix;
        s1_addr <= rd_addr;
        s1_valid <= is_pix;
        s1_emit <= do_emit_pix;
        if (is_pix) begin
          if (32'(in_col) + 1 >= 32'(w_eff)) begin
            in_col <= '0;
            in_row <= (32'(in_row) + 1 >= 32'(h_eff)) ? '0 : in_row + 1'b1;
          end else begin
            in_col <= in_col + 1'b1;
          end
          if (!do_emit_pix) pending <= pending + 1'b1;
        end else if (do_drain) begin
          pending <= pending - 1'b1;
        end
      end
      if (s1_valid || (acc && !is_pix && do_drain)) begin
        if (s1_valid) begin
          for (int i = 0; i < 3; i++) begin
            win[i*3]   <= win[i*3+1];
            win[i*3+1] <= win[i*3+2];
          end
          win[2] <= rd_top;
          win[5] <= rd_mid;
          win[8] <= s1_pix;
          s1_valid <= 1'b0;
        end
      end
      if (issue) begin
        job_valid <= 1'b1;
        job.row <= out_row;
        job.col <= out_col;
        job.interior <= (out_row >= 1) && (32'(out_row) + 2 <= 32'(h_eff)) &&
                        (out_col >= 1) && (32'(out_col) + 2 <= 32'(w_eff));
        job.last <= (32'(out_row) + 1 == 32'(h_eff)) &&
                    (32'(out_col) + 1 == 32'(w_eff));
        if (s1_valid) begin
          for (int i = 0; i < 3; i++) begin
            job.win[i*3]   <= win[i*3+1];
            job.win[i*3+1] <= win[i*3+2];
          end
          job.win[2] <= rd_top;
          job.win[5] <= rd_mid;
          job.win[8] <= s1_pix;
        end else begin
          job.win <= win;
        end
        if (32'(out_col) + 1 >= 32'(w_eff)) begin
          out_col <= '0;
          out_row <= (32'(out_row) + 1 >= 32'(h_eff)) ? '0 : out_row + 1'b1;
        end else begin
          out_col <= out_col + 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/c3nc_queue.sv -----
// ----------------------------------------------------------------------------
// c3nc_queue: two-entry job queue
// Decouples the front part from the arithmetic back part.
// ----------------------------------------------------------------------------
module c3nc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  c3nc_pkg::job_t  wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output c3nc_pkg::job_t  rd_data
);
  import c3nc_pkg::*;

  job_t       slots [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign wr_ready = cnt != 2'd2;
  assign rd_valid = cnt != 2'd0;
  assign rd_data  = slots[rp];

  // Write and read pointers with an occupancy count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= '0;
    end else begin
      if (wr_valid && wr_ready) begin
        slots[wp] <= wr_data;
        wp <= ~wp;
      end
      if (rd_valid && rd_ready) rp <= ~rp;
      cnt <= cnt + 2'((wr_valid && wr_ready) ? 1 : 0) - 2'((rd_valid && rd_ready) ? 1 : 0);
    end
  end
endmodule

// ----- rtl/c3nc_back.sv -----
// ----------------------------------------------------------------------------
// c3nc_back: tap products, serial division and clamp
// Forms the weighted sum, divides it by the tap total with a restoring divider,
// clamps and holds the result until taken.
// ----------------------------------------------------------------------------
module c3nc_back #(
  parameter int TAP_BITS = c3nc_pkg::TAP_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [c3nc_pkg::TAPS_W-1:0]  taps,
  input  logic                         job_valid,
  output logic                         job_ready,
  input  c3nc_pkg::job_t               job,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic [c3nc_pkg::PIX_W-1:0]   res_pix,
  output logic [c3nc_pkg::ROW_W-1:0]   res_row,
  output logic [c3nc_pkg::COL_W-1:0]   res_col,
  output logic                         res_last
);
  import c3nc_pkg::*;

  localparam int SW = TAP_BITS + PIX_W + 5;
  localparam int TW = TAP_BITS + 4;

  typedef enum logic [1:0] {B_IDLE, B_SUM, B_DIV, B_DONE} bst_t;
  bst_t st, st_next;

  job_t               cur;
  logic signed [SW-1:0] prod [9];
  logic signed [TW-1:0] total;
  logic [SW-1:0]      num, quo, rem;
  logic [TW-1:0]      den;
  logic               neg;
  logic [$clog2(SW+1)-1:0] cnt;
  logic [SW:0]        trial;

  function automatic logic signed [TW-1:0] tap_at(input logic [TAPS_W-1:0] t, input int k);
    logic signed [TAP_BITS-1:0] f;
    f = '0;
    if (TAP_BITS * k + TAP_BITS <= TAPS_W) f = t[TAP_BITS*k +: TAP_BITS];
    return TW'(f);
  endfunction

  // Products and tap total for the held window.
  always_comb begin
    total = '0;
    for (int k = 0; k < 9; k++) begin
      prod[k] = SW'(tap_at(taps, k)) * $signed({1'b0, cur.win[k]});
      total = total + tap_at(taps, k);
    end
  end

  assign trial = {rem[SW-2:0], num[SW-1]} - (SW+1)'(den);
  assign job_ready = (st == B_IDLE);
  assign res_valid = (st == B_DONE);

  always_ff @(posedge clk) begin
    if (rst) st <= B_IDLE;
    else st <= st_next;
  end

  always_comb begin
    st_next = st;
    unique case (st)
      B_IDLE: if (job_valid) st_next = B_SUM;
      B_SUM:  st_next = B_DIV;
      B_DIV:  if (cnt == '0) st_next = B_DONE;
      B_DONE: if (res_ready) st_next = B_IDLE;
      default: st_next = B_IDLE;
    endcase
  end

  // Datapath: latch job, sum, shift-subtract divide, then clamp.
  always_ff @(posedge clk) begin
    logic signed [SW-1:0] s;
    logic signed [TW-1:0] d;
    logic signed [SW:0]   q;
    s = '0;
    d = '0;
    q = '0;
    if (st == B_IDLE && job_valid) cur <= job;
    if (st == B_SUM) begin
      for (int k = 0; k < 9; k++) s = s + prod[k];
      d = (total == '0) ? TW'(1) : total;
      neg <= s[SW-1] ^ d[TW-1];
      num <= s[SW-1] ? SW'(-s) : SW'(s);
      den <= d[TW-1] ? TW'(-d) : TW'(d);
      rem <= '0;
      quo <= '0;
      cnt <= ($clog2(SW+1))'(SW);
    end
    if (st == B_DIV && cnt != '0) begin
      if (!trial[SW]) rem <= trial[SW-1:0];
      else rem <= {rem[SW-2:0], num[SW-1]};
      num <= {num[SW-2:0], 1'b0};
      quo <= {quo[SW-2:0], !trial[SW]};
      cnt <= cnt - 1'b1;
    end
    if (st == B_DIV && cnt == '0) begin
      q = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
      res_row  <= cur.row;
      res_col  <= cur.col;
      res_last <= cur.last;
      if (!cur.interior || q < 0) res_pix <= '0;
      else if (q > PIX_MAX) res_pix <= PIX_W'(PIX_MAX);
      else res_pix <= q[PIX_W-1:0];
    end
  end

endmodule

// ----- rtl/c3nc_checker.sv -----
// ----------------------------------------------------------------------------
// c3nc_checker: port-level checks for the convolution block
// Watches the output channel over time.
// ----------------------------------------------------------------------------
module c3nc_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_pix,
  input logic [8:0]  out_col,
  input logic        out_last
);
  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_pix))
    else $error("output changed while stalled");
  // The left border column is always zero.
  a_border: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_col == 9'd0 |-> out_pix == 8'd0)
    else $error("left border pixel not zero");
  // No output right after reset.
  a_reset: assert property (@(posedge clk) !rst && $past(rst) |-> !out_valid)
    else $error("output valid right after reset");
  // Frame end on a pixel implies that pixel is border and zero.
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_pix == 8'd0)
    else $error("frame end pixel not zero");
endmodule

bind conv3x3_normalized_clamp c3nc_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_pix(out_ch.data.result_pixel), .out_col(out_ch.data.out_col),
  .out_last(out_ch.data.frame_end)
);
